// ===== sv/bitmap_id_allocator_assert.svh =====
// Assertion macros for the bitmap ID allocator.
// Depends on nothing; included by the modules that check their own logic.
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BIA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BIA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bia_pkg.sv =====
// Shared types and constants for the bitmap ID allocator.
// No dependencies; used by the top level by scoped names.
package bia_pkg;

  // Fixed field widths
  localparam int ID_W  = 10;
  localparam int CFG_W = 11;

  // Bitmap word organization
  localparam int WORD_W     = 32;
  localparam int WORD_SHIFT = 5;

  // Defaults
  localparam int POOL_DEPTH_DEF = 1024;
  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_BORROW_NEXT = 2'd0,
    OP_BORROW_ID   = 2'd1,
    OP_RETURN_ID   = 2'd2,
    OP_RETURN_ALL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_CHECK,
    S_CLEAR,
    S_RESP
  } state_e;

endpackage

// ===== sv/bia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free bitmap of the ID allocator.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bitmap_id_allocator.sv =====
// Bitmap ID allocator top level; uses bia_pkg, bia_ram and the assertion header.
// Accept to result valid: borrow specific and return go through S_START, S_CHECK and S_RESP
// (skipping S_CHECK when the ID is out of range); borrow next repeats S_CHECK per extra 32-ID
// word scanned (skips it with the pointer at the pool size); return all sweeps every word in
// S_CLEAR. One item at a time: the block is back in S_IDLE as the result turns valid and takes
// the next item only there. Reset sweeps every word free in S_INIT with the input stalled.
`include "bitmap_id_allocator_assert.svh"

module bitmap_id_allocator #(
  parameter int POOL_DEPTH = bia_pkg::POOL_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [bia_pkg::ID_W-1:0] id_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bia_pkg::ID_W-1:0] result_id_o,
  output logic                     ok_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bia_pkg::CFG_W-1:0] cfg_pool_size_i
);

  localparam int WORD_W    = bia_pkg::WORD_W;
  localparam int OFF_W     = bia_pkg::WORD_SHIFT;
  localparam int ID_W      = bia_pkg::ID_W;
  localparam int NUM_WORDS = (POOL_DEPTH + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W     = $clog2(POOL_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam logic [PTR_W-1:0]  DEPTH_P   = PTR_W'(POOL_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_RST   = PTR_W'(1);

  bia_pkg::state_e state_q, state_d;
  bia_pkg::op_e    op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [bia_pkg::CFG_W-1:0] pool_q;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic              res_ok_q, res_ok_d;
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_ok_q, out_ok_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [PTR_W-1:0]  live_size;
  logic              id_in_range;
  logic [ADDR_W-1:0] id_word, ptr_word;
  logic [WORD_W-1:0] id_bit, lo_mask, hi_mask, cand;
  logic [OFF_W-1:0]  ptr_off, size_off, pos;
  logic              found;
  logic [PTR_W-1:0]  found_ptr;
  logic [31:0]       next_base;

  // Free bitmap, one bit per ID, 1 = free
  bia_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Saturate the configured pool size to the bitmap depth
  always_comb begin
    if (32'(pool_q) > 32'(POOL_DEPTH)) begin
      live_size = DEPTH_P;
    end else begin
      live_size = PTR_W'(pool_q);
    end
  end

  // Address and bit decode for the requested ID and the scan pointer
  assign id_in_range = 32'(id_q) < 32'(live_size);
  assign id_word     = ADDR_W'(32'(id_q) >> OFF_W);
  assign id_bit      = WORD_W'(1) << id_q[OFF_W-1:0];
  assign ptr_word    = ADDR_W'(32'(ptr_q) >> OFF_W);
  assign ptr_off     = OFF_W'(32'(ptr_q));
  assign size_off    = OFF_W'(32'(live_size));

  // Candidate bits in the scanned word: at or above the pointer, below the pool size
  assign lo_mask = {WORD_W{1'b1}} << ptr_off;
  assign hi_mask = ((32'(live_size) >> OFF_W) == 32'(addr_q)) ?
                   ((WORD_W'(1) << size_off) - WORD_W'(1)) : {WORD_W{1'b1}};
  assign cand    = ram_rdata & lo_mask & hi_mask;
  assign found   = |cand;

  // Lowest free candidate
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = OFF_W'(i);
      end
    end
  end

  assign found_ptr = PTR_W'((32'(addr_q) << OFF_W) | 32'(pos));
  assign next_base = (32'(addr_q) + 32'd1) << OFF_W;

  // Sequencer: next state, bitmap access and result
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    ptr_d      = ptr_q;
    addr_d     = addr_q;
    res_id_d   = res_id_q;
    res_ok_d   = res_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = addr_q;
    in_stall_o = 1'b1;
    out_id_d   = out_id_q;
    out_ok_d   = out_ok_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      bia_pkg::S_INIT: begin
        // Mark every word free after reset
        ram_we    = 1'b1;
        ram_wdata = {WORD_W{1'b1}};
        if (addr_q == LAST_WORD) begin
          addr_d  = '0;
          state_d = bia_pkg::S_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      bia_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = bia_pkg::op_e'(operation_i);
          id_d    = id_i;
          state_d = bia_pkg::S_START;
        end
      end
      bia_pkg::S_START: begin
        case (op_q)
          bia_pkg::OP_BORROW_NEXT: begin
            if (32'(ptr_q) < 32'(live_size)) begin
              addr_d    = ptr_word;
              ram_re    = 1'b1;
              ram_raddr = ptr_word;
              state_d   = bia_pkg::S_CHECK;
            end else begin
              res_id_d = '0;
              res_ok_d = 1'b0;
              state_d  = bia_pkg::S_RESP;
            end
          end
          bia_pkg::OP_BORROW_ID, bia_pkg::OP_RETURN_ID: begin
            res_id_d = id_q;
            if (id_in_range) begin
              addr_d    = id_word;
              ram_re    = 1'b1;
              ram_raddr = id_word;
              state_d   = bia_pkg::S_CHECK;
            end else begin
              res_ok_d = 1'b0;
              state_d  = bia_pkg::S_RESP;
            end
          end
          default: begin
            addr_d  = '0;
            state_d = bia_pkg::S_CLEAR;
          end
        endcase
      end
      bia_pkg::S_CHECK: begin
        case (op_q)
          bia_pkg::OP_BORROW_NEXT: begin
            if (found) begin
              // Claim the lowest free ID and leave the pointer on it
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~(WORD_W'(1) << pos);
              ptr_d     = found_ptr;
              res_id_d  = ID_W'(found_ptr);
              res_ok_d  = 1'b1;
              state_d   = bia_pkg::S_RESP;
            end else if (next_base >= 32'(live_size)) begin
              // Pool exhausted: park the pointer at the pool size
              ptr_d    = live_size;
              res_id_d = '0;
              res_ok_d = 1'b0;
              state_d  = bia_pkg::S_RESP;
            end else begin
              // Advance to the next word
              ptr_d     = PTR_W'(next_base);
              addr_d    = addr_q + ADDR_W'(1);
              ram_re    = 1'b1;
              ram_raddr = addr_q + ADDR_W'(1);
            end
          end
          bia_pkg::OP_BORROW_ID: begin
            if ((ram_rdata & id_bit) != '0) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~id_bit;
              res_ok_d  = 1'b1;
            end else begin
              res_ok_d = 1'b0;
            end
            state_d = bia_pkg::S_RESP;
          end
          bia_pkg::OP_RETURN_ID: begin
            // Free the ID and pull the pointer down to it
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | id_bit;
            if (32'(id_q) < 32'(ptr_q)) begin
              ptr_d = PTR_W'(id_q);
            end
            res_ok_d = 1'b1;
            state_d  = bia_pkg::S_RESP;
          end
          default: begin
            res_ok_d = 1'b0;
            state_d  = bia_pkg::S_RESP;
          end
        endcase
      end
      bia_pkg::S_CLEAR: begin
        // Return all: sweep every word back to free
        ram_we    = 1'b1;
        ram_wdata = {WORD_W{1'b1}};
        if (addr_q == LAST_WORD) begin
          ptr_d    = PTR_RST;
          res_id_d = id_q;
          res_ok_d = 1'b1;
          state_d  = bia_pkg::S_RESP;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      bia_pkg::S_RESP: begin
        // Hand the item to the output register once it has room
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_ok_d    = res_ok_q;
          state_d     = bia_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bia_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bia_pkg::S_INIT;
      ptr_q       <= PTR_RST;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pool size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= bia_pkg::POOL_SIZE_RST;
    end else if (cfg_valid_i) begin
      pool_q <= cfg_pool_size_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    res_id_q <= res_id_d;
    res_ok_q <= res_ok_d;
    out_id_q <= out_id_d;
    out_ok_q <= out_ok_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign result_id_o = out_id_q;
  assign ok_o        = out_ok_q;

  `BIA_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o,
                  state_q == bia_pkg::S_START, "accepted item did not start")
  `BIA_ASSERT_IMP(a_write_states, clk_i, rst_ni, ram_we,
                  state_q == bia_pkg::S_INIT || state_q == bia_pkg::S_CHECK ||
                  state_q == bia_pkg::S_CLEAR, "bitmap written outside a write state")
  `BIA_ASSERT_IMP(a_ptr_bound, clk_i, rst_ni, 1'b1, 32'(ptr_q) <= 32'(POOL_DEPTH),
                  "scan pointer beyond pool depth")
  `BIA_ASSERT_NXT(a_resp_loads, clk_i, rst_ni,
                  state_q == bia_pkg::S_RESP && (!out_valid_q || !out_stall_i),
                  out_valid_q && state_q == bia_pkg::S_IDLE,
                  "result not loaded into output register")

endmodule

// ===== verif/bitmap_id_allocator_test.sv =====
// Self-checking testbench for bitmap_id_allocator: directed table, then random phases per pool size.
// Depends on bia_pkg and the bitmap_id_allocator RTL; needs no files or arguments.
module bitmap_id_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W        = bia_pkg::ID_W;
  localparam int CFG_W       = bia_pkg::CFG_W;
  localparam int POOL_DEPTH  = bia_pkg::POOL_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 132;
  localparam int ROWS        = 27;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            ok;
  } grant_t;

  typedef struct packed {
    logic             set_pool;
    logic [CFG_W-1:0] pool;
    bia_pkg::op_e     op;
    logic [ID_W-1:0]  id;
    logic             typed;
    logic [ID_W-1:0]  want_id;
    logic             want_ok;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        operation_i;
  logic [ID_W-1:0]   id_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ID_W-1:0]   result_id_o;
  logic              ok_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_pool_size_i;

  // Allocator mirror: free bits, low-water pointer, pool size
  bit               id_free [POOL_DEPTH];
  int unsigned      low_water;
  logic [CFG_W-1:0] pool_cfg;

  grant_t           pending_grants [$];
  logic [ID_W-1:0]  held_ids [$];

  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned refusals;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned cycles;
  int unsigned burst_left;
  logic        hold_off;

  // Directed table; typed rows carry their result, the rest go through the mirror
  stim_row_t plan [ROWS] = '{
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b1, 10'd1,    1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'd0,    1'b1, 10'd0,    1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'd0,    1'b1, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'd1023, 1'b1, 10'd1023, 1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'h2AA,  1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'h155,  1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ID,   10'd1023, 1'b1, 10'd1023, 1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ID,   10'd0,    1'b1, 10'd0,    1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'h3FF,  1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ID,   10'd7,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ALL,  10'h3FF,  1'b1, 10'h3FF,  1'b1},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b1, 10'd1,    1'b1},
    '{1'b1, 11'd4,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'd4,    1'b1, 10'd4,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ID,   10'd1000, 1'b1, 10'd1000, 1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd5,    1'b1, 10'd0,    1'b0},
    '{1'b1, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd9,    1'b1, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ID,   10'd0,    1'b1, 10'd0,    1'b0},
    '{1'b1, 11'd2047, bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_NEXT, 10'd0,    1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_BORROW_ID,   10'd1023, 1'b0, 10'd0,    1'b0},
    '{1'b0, 11'd0,    bia_pkg::OP_RETURN_ALL,  10'd0,    1'b1, 10'd0,    1'b1}
  };

  int unsigned phase_pool [PHASES] =
    '{1024, 1, 2, 33, 0, 2047, 64, 31, 1000, 0, 0, 32, 5, 1024};
  int unsigned phase_bias [PHASES] =
    '{60, 50, 40, 45, 50, 55, 70, 45, 75, 50, 50, 65, 40, 35};

  bitmap_id_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .id_i            (id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_id_o     (result_id_o),
    .ok_o            (ok_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_pool_size_i (cfg_pool_size_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pool size as the block uses it: saturate at the bitmap depth
  function automatic int unsigned live_pool();
    return (pool_cfg > POOL_DEPTH) ? POOL_DEPTH : int'(pool_cfg);
  endfunction

  function automatic void free_all_ids();
    foreach (id_free[i]) id_free[i] = 1'b1;
    low_water = 1;
  endfunction

  // Apply one item to the mirror and return the grant it produces
  function automatic grant_t allocate_step(bia_pkg::op_e op, logic [ID_W-1:0] id);
    grant_t      g;
    int unsigned size;
    size = live_pool();
    g.id = id;
    g.ok = 1'b0;
    case (op)
      bia_pkg::OP_BORROW_NEXT: begin
        while (low_water < size && !id_free[low_water]) low_water++;
        if (low_water < size) begin
          id_free[low_water] = 1'b0;
          g.id = low_water[ID_W-1:0];
          g.ok = 1'b1;
        end else begin
          g.id = '0;
        end
      end
      bia_pkg::OP_BORROW_ID: begin
        if (id < size && id_free[id]) begin
          id_free[id] = 1'b0;
          g.ok = 1'b1;
        end
      end
      bia_pkg::OP_RETURN_ID: begin
        if (id < size) begin
          id_free[id] = 1'b1;
          if (id < low_water) low_water = id;
          g.ok = 1'b1;
        end
      end
      default: begin
        free_all_ids();
        g.ok = 1'b1;
      end
    endcase
    return g;
  endfunction

  // Sender gap: mostly none or short, a few long, with gap-free bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, what);
  endtask

  // Offer one item, wait for acceptance, then record the grant it should get
  task automatic offer_item(bia_pkg::op_e op, logic [ID_W-1:0] id, logic typed,
                            grant_t typed_grant);
    int unsigned gap;
    grant_t      g;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    id_i        <= id;
    do @(posedge clk_i); while (in_stall_o);
    g = allocate_step(op, id);
    pending_grants.push_back(typed ? typed_grant : g);
    items_accepted++;
    if (op == bia_pkg::OP_RETURN_ALL) held_ids.delete();
    else if (op != bia_pkg::OP_RETURN_ID && g.ok) held_ids.push_back(g.id);
  endtask

  // Drop valid, wait for every grant, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [CFG_W-1:0] value);
    settle();
    cfg_valid_i     <= 1'b1;
    cfg_pool_size_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_cfg = value;
    settings_used++;
  endtask

  // Pick an ID: mostly inside the live pool, sometimes anywhere in the field
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned size;
    size = live_pool();
    if (size != 0 && $urandom_range(0, 4) != 0) return ID_W'($urandom_range(0, size - 1));
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  task automatic random_item(int unsigned bias);
    int unsigned     r;
    int unsigned     idx;
    bia_pkg::op_e    op;
    logic [ID_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = pick_id();
    if (r < 2) begin
      op = bia_pkg::OP_RETURN_ALL;
    end else if (r < 2 + bias) begin
      op = bia_pkg::OP_BORROW_NEXT;
      id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
    end else if (r < 2 + bias + (98 - bias) / 3) begin
      op = bia_pkg::OP_BORROW_ID;
    end else begin
      op = bia_pkg::OP_RETURN_ID;
      // Mostly hand back an ID that is actually held
      if (held_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, held_ids.size() - 1);
        id  = held_ids[idx];
        held_ids.delete(idx);
      end
    end
    offer_item(op, id, 1'b0, '0);
  endtask

  // Receiver: runs of stall and no stall, plus the long hold-off
  initial begin : drive_stall
    int unsigned run_left;
    int unsigned r;
    logic        run_stall;
    out_stall_i = 1'b0;
    run_left    = 0;
    run_stall   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(1, 20);
        end else if (r < 85) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(1, 3);
        end else if (r < 95) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(50, 150);
        end else begin
          run_stall = 1'b1;
          run_left  = $urandom_range(20, 40);
        end
      end
      run_left--;
      out_stall_i <= hold_off | run_stall;
    end
  end

  // Hold the output off long enough that the block backs up into its input
  initial begin
    hold_off = 1'b0;
    while (items_accepted < 500) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Compare each accepted result with the oldest grant waiting
  always @(posedge clk_i) begin : check_grants
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch($sformatf("unexpected result id=%0d ok=%0b", result_id_o, ok_o));
      end else begin
        want = pending_grants.pop_front();
        if (result_id_o !== want.id)
          flag_mismatch($sformatf("result_id expected %0d got %0d", want.id, result_id_o));
        if (ok_o !== want.ok)
          flag_mismatch($sformatf("ok expected %0b got %0b (id %0d)", want.ok, ok_o, want.id));
        results_checked++;
        if (!want.ok) refusals++;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_grants.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : run_stimulus
    stim_row_t row;
    grant_t    typed_grant;
    items_accepted  = 0;
    results_checked = 0;
    refusals        = 0;
    mismatches      = 0;
    settings_used   = 0;
    cycles          = 0;
    burst_left      = 0;
    pool_cfg        = bia_pkg::POOL_SIZE_RST;
    free_all_ids();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = bia_pkg::OP_BORROW_NEXT;
    id_i            = '0;
    cfg_valid_i     = 1'b0;
    cfg_pool_size_i = '0;
    phase_pool[9]   = $urandom_range(1, POOL_DEPTH);
    phase_pool[10]  = $urandom_range(POOL_DEPTH + 1, (1 << CFG_W) - 1);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (plan[i]) begin
      row = plan[i];
      if (row.set_pool) begin
        write_pool_size(row.pool);
      end else begin
        typed_grant.id = row.want_id;
        typed_grant.ok = row.want_ok;
        offer_item(row.op, row.id, row.typed, typed_grant);
      end
    end

    // Random phases, one pool size each; state carries across phases
    for (int p = 0; p < PHASES; p++) begin
      write_pool_size(CFG_W'(phase_pool[p]));
      repeat (PHASE_ITEMS) random_item(phase_bias[p]);
    end

    settle();
    $display("Covered %0d items over %0d pool settings, including empty and saturated pools.",
             items_accepted, settings_used);
    $display("Checked %0d results, %0d of them refusals (none left, taken or out of range).",
             results_checked, refusals);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_grants.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
